@@ hw/rtl/lkd_pkg.sv @@
// Package with the sizes and constants of the ladder keypad debouncer.
`default_nettype none

package lkd_pkg;

  // Keypad shape and sample size.
  localparam int unsigned BUTTONS  = 4;
  localparam int unsigned ADC_BITS = 10;

  // Register widths.
  localparam int unsigned OHM_W = 20;
  localparam int unsigned TOL_W = 8;
  localparam int unsigned DLY_W = 16;
  localparam int unsigned CFG_W = 20;
  localparam int unsigned CFG_IDX_W = 3;

  // Key codes.
  localparam int unsigned KEY_W  = 3;
  localparam int unsigned KIDX_W = 2;
  localparam logic [KEY_W-1:0] NO_KEY = 3'd4;

  // Debounce counter.
  localparam logic [DLY_W-1:0] CNT_MAX = '1;

  // Shared multiplier: a wide operand taken in two halves times a narrow operand.
  localparam int unsigned WA_W   = 48;
  localparam int unsigned HALF_W = WA_W / 2;
  localparam int unsigned NB_W   = (ADC_BITS + 9 > OHM_W) ? ADC_BITS + 9 : OHM_W;
  localparam int unsigned PROD_W = HALF_W + NB_W;
  localparam int unsigned RES_W  = WA_W + NB_W;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_LADDER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUND  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOL     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY0    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3    = 3'd7;

endpackage

`default_nettype wire

@@ hw/rtl/ladder_keypad_debouncer.sv @@
// Top level of the ladder keypad debouncer: decode sequencer, shared multiplier and debounce.
`default_nettype none

// Each input item is one ADC sample of a resistor-ladder keypad, taken once per
// tick. The block decodes the sample to key 0..3 or to no key (code 4) by trying
// each key's window in turn, lowest index first, with exact integer arithmetic,
// then debounces the decode with a per-value tick delay and reports a press or
// release event on the tick the stable value changes. Every input item yields one
// result item carrying the event flags and the raw decode. All multiplication runs
// through one 24 by 20 bit multiplier under a small sequencer; each product of a
// wide by a narrow operand runs a low-half, a high-half and a sum phase. After the
// step RG, the steps N, S, SADD, T, D, DADD, M, L and H run once for each key tried
// (the matching key and all below it, or all keys when none matches). The input is
// stalled from acceptance until the result is loaded; a finished result waits in
// the output register and does not block the next item. Configuration registers
// are to be written through a simple write port only while the block is idle; the
// block does not enforce this. They take effect on the next item.

module ladder_keypad_debouncer
  import lkd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Configuration write port.
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  // Sample input.
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [ADC_BITS-1:0]  adc_sample_i,
  // Result output.
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      event_valid_o,
  output logic                      key_pressed_o,
  output logic [KIDX_W-1:0]         key_index_o,
  output logic [KEY_W-1:0]          raw_key_o
);

  // Sequencer steps. Steps that multiply run three phases.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RG   = 4'd1;  // ladder * ground
  localparam logic [3:0] ST_N    = 4'd2;  // N = i * (ladder * ground)
  localparam logic [3:0] ST_S    = 4'd3;  // i * ladder
  localparam logic [3:0] ST_SADD = 4'd4;  // S = i * ladder + ground
  localparam logic [3:0] ST_T    = 4'd5;  // T = ladder * S
  localparam logic [3:0] ST_D    = 4'd6;  // j * T
  localparam logic [3:0] ST_DADD = 4'd7;  // D = j * T + N
  localparam logic [3:0] ST_M    = 4'd8;  // M = D * adc * 256
  localparam logic [3:0] ST_L    = 4'd9;  // lower bound, compare with M
  localparam logic [3:0] ST_H    = 4'd10; // upper bound, compare with M
  localparam logic [3:0] ST_FIN  = 4'd11; // debounce and load result

  localparam logic [1:0] PH_LO  = 2'd0;
  localparam logic [1:0] PH_HI  = 2'd1;
  localparam logic [1:0] PH_SUM = 2'd2;

  localparam logic [KIDX_W-1:0] LAST_KEY = KIDX_W'(BUTTONS - 1);

  // Configuration registers.
  logic [OHM_W-1:0] ladder_q, ground_q;
  logic [TOL_W-1:0] tol_q;
  logic [DLY_W-1:0] rel_dly_q;
  logic [DLY_W-1:0] key_dly_q [4];

  // Debounce state.
  logic [KEY_W-1:0] last_q, stable_q;
  logic [DLY_W-1:0] elapsed_q;

  // Sequencer and datapath registers.
  logic [3:0]          step_q;
  logic [1:0]          ph_q;
  logic [KIDX_W-1:0]   k_q;
  logic [ADC_BITS-1:0] adc_q;
  logic [NB_W-1:0]     cl_q, ch_q;
  logic [WA_W-1:0]     p1_q, n_q, s_q, t_q, d_q;
  logic [RES_W-1:0]    m_q;
  logic                lo_ok_q;
  logic [KEY_W-1:0]    raw_q;
  logic [PROD_W-1:0]   prod_q;
  logic [PROD_W-1:0]   acc_q;

  // Output register.
  logic              out_valid_q;
  logic              ev_q, pr_q;
  logic [KIDX_W-1:0] idx_q;
  logic [KEY_W-1:0]  okey_q;

  // Shared multiplier operands.
  logic [WA_W-1:0]   mul_wa;
  logic [NB_W-1:0]   mul_nb;
  logic [HALF_W-1:0] mul_half;
  logic [PROD_W-1:0] prod_d;
  logic [RES_W-1:0]  mul_res;
  logic [NB_W-1:0]   key_i, key_j;
  logic [NB_W-1:0]   cl_d, ch_d;

  // Debounce datapath.
  logic [DLY_W-1:0] delay_sel;
  logic [DLY_W-1:0] elapsed_d;
  logic             take_new;
  logic             out_free;

  // Key k sits below k+1 ladder resistors, with BUTTONS-k of them in
  // parallel with the ground resistor.
  assign key_i = NB_W'(BUTTONS) - NB_W'(k_q);
  assign key_j = NB_W'(k_q) + NB_W'(1);

  // Window bounds scaled by full scale: x * (2^ADC_BITS - 1).
  assign cl_d = (NB_W'(9'd256 - {1'b0, tol_q}) << ADC_BITS) - NB_W'(9'd256 - {1'b0, tol_q});
  assign ch_d = (NB_W'(9'd256 + {1'b0, tol_q}) << ADC_BITS) - NB_W'(9'd256 + {1'b0, tol_q});

  always_comb begin
    mul_wa = '0;
    mul_nb = '0;
    case (step_q)
      ST_RG: begin
        mul_wa = WA_W'(ground_q);
        mul_nb = NB_W'(ladder_q);
      end
      ST_N: begin
        mul_wa = p1_q;
        mul_nb = key_i;
      end
      ST_S: begin
        mul_wa = WA_W'(ladder_q);
        mul_nb = key_i;
      end
      ST_T: begin
        mul_wa = s_q;
        mul_nb = NB_W'(ladder_q);
      end
      ST_D: begin
        mul_wa = t_q;
        mul_nb = key_j;
      end
      ST_M: begin
        mul_wa = d_q;
        mul_nb = NB_W'({adc_q, 8'd0});
      end
      ST_L: begin
        mul_wa = n_q;
        mul_nb = cl_q;
      end
      ST_H: begin
        mul_wa = n_q;
        mul_nb = ch_q;
      end
      default: begin
        mul_wa = '0;
        mul_nb = '0;
      end
    endcase
  end

  // Low half in the first phase, high half in the second.
  assign mul_half = (ph_q == PH_LO) ? mul_wa[HALF_W-1:0] : mul_wa[WA_W-1:HALF_W];
  assign prod_d   = PROD_W'(mul_half) * PROD_W'(mul_nb);
  assign mul_res  = RES_W'(acc_q) + (RES_W'(prod_q) << HALF_W);

  // Debounce of the finished decode.
  always_comb begin
    case (raw_q)
      3'd0:    delay_sel = key_dly_q[0];
      3'd1:    delay_sel = key_dly_q[1];
      3'd2:    delay_sel = key_dly_q[2];
      3'd3:    delay_sel = key_dly_q[3];
      default: delay_sel = rel_dly_q;
    endcase
  end

  assign elapsed_d = (raw_q != last_q) ? '0 :
                     (elapsed_q == CNT_MAX) ? elapsed_q : elapsed_q + DLY_W'(1);
  assign take_new  = (elapsed_d > delay_sel) && (raw_q != stable_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ladder_q     <= OHM_W'(10000);
      ground_q     <= OHM_W'(10000);
      tol_q        <= TOL_W'(26);
      rel_dly_q    <= DLY_W'(50);
      key_dly_q[0] <= DLY_W'(50);
      key_dly_q[1] <= DLY_W'(50);
      key_dly_q[2] <= DLY_W'(50);
      key_dly_q[3] <= DLY_W'(50);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LADDER:  ladder_q     <= cfg_data_i[OHM_W-1:0];
        REG_GROUND:  ground_q     <= cfg_data_i[OHM_W-1:0];
        REG_TOL:     tol_q        <= cfg_data_i[TOL_W-1:0];
        REG_RELEASE: rel_dly_q    <= cfg_data_i[DLY_W-1:0];
        REG_KEY0:    key_dly_q[0] <= cfg_data_i[DLY_W-1:0];
        REG_KEY1:    key_dly_q[1] <= cfg_data_i[DLY_W-1:0];
        REG_KEY2:    key_dly_q[2] <= cfg_data_i[DLY_W-1:0];
        REG_KEY3:    key_dly_q[3] <= cfg_data_i[DLY_W-1:0];
        default:     ;
      endcase
    end
  end

  // Multiplier pipeline: product register, then the accumulator takes the low-half product in the high phase.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (ph_q == PH_HI) begin
      acc_q <= prod_q;
    end
  end

  // Sequencer and debounce state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_IDLE;
      ph_q        <= PH_LO;
      k_q         <= '0;
      last_q      <= NO_KEY;
      stable_q    <= NO_KEY;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // A new result loads the output register; otherwise a taken one empties it.
      if (step_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // Phase counter for the multiplying steps.
      if (step_q == ST_IDLE || step_q == ST_SADD || step_q == ST_DADD ||
          step_q == ST_FIN) begin
        ph_q <= PH_LO;
      end else if (ph_q == PH_SUM) begin
        ph_q <= PH_LO;
      end else begin
        ph_q <= ph_q + 2'd1;
      end

      case (step_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            adc_q  <= adc_sample_i;
            k_q    <= '0;
            step_q <= ST_RG;
          end
        end
        ST_RG: begin
          if (ph_q == PH_SUM) begin
            p1_q   <= mul_res[WA_W-1:0];
            cl_q   <= cl_d;
            ch_q   <= ch_d;
            step_q <= ST_N;
          end
        end
        ST_N: begin
          if (ph_q == PH_SUM) begin
            n_q    <= mul_res[WA_W-1:0];
            step_q <= ST_S;
          end
        end
        ST_S: begin
          if (ph_q == PH_SUM) begin
            s_q    <= mul_res[WA_W-1:0];
            step_q <= ST_SADD;
          end
        end
        ST_SADD: begin
          s_q    <= s_q + WA_W'(ground_q);
          step_q <= ST_T;
        end
        ST_T: begin
          if (ph_q == PH_SUM) begin
            t_q    <= mul_res[WA_W-1:0];
            step_q <= ST_D;
          end
        end
        ST_D: begin
          if (ph_q == PH_SUM) begin
            d_q    <= mul_res[WA_W-1:0];
            step_q <= ST_DADD;
          end
        end
        ST_DADD: begin
          d_q    <= d_q + n_q;
          step_q <= ST_M;
        end
        ST_M: begin
          if (ph_q == PH_SUM) begin
            m_q    <= mul_res;
            step_q <= ST_L;
          end
        end
        ST_L: begin
          if (ph_q == PH_SUM) begin
            lo_ok_q <= (mul_res < m_q);
            step_q  <= ST_H;
          end
        end
        ST_H: begin
          if (ph_q == PH_SUM) begin
            // A zero N or D leaves both bounds at zero, so no window holds.
            if (lo_ok_q && (m_q < mul_res)) begin
              raw_q  <= KEY_W'(k_q);
              step_q <= ST_FIN;
            end else if (k_q == LAST_KEY) begin
              raw_q  <= NO_KEY;
              step_q <= ST_FIN;
            end else begin
              k_q    <= k_q + KIDX_W'(1);
              step_q <= ST_N;
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            elapsed_q   <= elapsed_d;
            last_q      <= raw_q;
            if (take_new) begin
              stable_q <= raw_q;
            end
            ev_q        <= take_new;
            pr_q        <= take_new && (raw_q != NO_KEY);
            idx_q       <= (take_new && (raw_q != NO_KEY)) ? raw_q[KIDX_W-1:0] : '0;
            okey_q      <= raw_q;
            step_q      <= ST_IDLE;
          end
        end
        default: begin
          step_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o    = (step_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign event_valid_o = ev_q;
  assign key_pressed_o = pr_q;
  assign key_index_o   = idx_q;
  assign raw_key_o     = okey_q;

endmodule

`default_nettype wire
